// ===== rtl/fbtd_pkg.sv =====
// Package for the factor-base trial division block.
// Holds shared widths, defaults and operation codes; no dependencies.
package fbtd_pkg;
    localparam int BASE_DEPTH_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int PRIME_W = 32;
    localparam int IDX_W   = 6;
    localparam int EXP_W   = 6;
    localparam int CNT_W   = 7;
    localparam int FIELD_W = 64;
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FACTOR = 1'b1;
endpackage

// ===== rtl/fbtd_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
// Depends on fbtd_pkg for field widths.
interface fbtd_in_if;
    import fbtd_pkg::*;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [IDX_W-1:0]    entry_index;
    logic [PRIME_W-1:0]  prime_value;
    logic signed [FIELD_W-1:0] value;
    modport source (output valid, operation, entry_index, prime_value, value, input ready);
    modport sink   (input valid, operation, entry_index, prime_value, value, output ready);
endinterface

interface fbtd_out_if;
    import fbtd_pkg::*;
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    base_position;
    logic [EXP_W-1:0]    exponent;
    logic                last;
    logic signed [FIELD_W-1:0] cofactor;
    logic                smooth;
    logic                all_even;
    logic                zero_input;
    modport source (output valid, base_position, exponent, last, cofactor, smooth, all_even,
                    zero_input, input ready);
    modport sink   (input valid, base_position, exponent, last, cofactor, smooth, all_even,
                    zero_input, output ready);
endinterface

// ===== rtl/fbtd_divider.sv =====
// Bit-serial restoring divider: magnitude by 32-bit prime, one quotient bit a cycle.
// Depends on fbtd_pkg.
module fbtd_divider #(
    parameter int VALUE_WIDTH = fbtd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [VALUE_WIDTH-1:0]      i_dividend,
    input  logic [fbtd_pkg::PRIME_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_quotient,
    output logic                        o_exact
);
    import fbtd_pkg::*;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_q, n_q;
    logic [PRIME_W:0]       r_rem, n_rem;
    logic [PRIME_W-1:0]     r_div;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_busy, n_busy, r_done, n_done;
    logic [PRIME_W:0]       w_trial;
    logic [PRIME_W+1:0]     w_diff;

    always_comb begin
        w_trial = {r_rem[PRIME_W-1:0], r_q[VALUE_WIDTH-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_div};
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_q = i_dividend; n_rem = '0; n_cnt = CW'(VALUE_WIDTH); n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[PRIME_W+1]) begin
                n_rem = w_diff[PRIME_W:0];
                n_q   = {r_q[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[VALUE_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem;
        if (i_start) r_div <= i_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
    assign o_exact    = (r_rem == '0);
endmodule

// ===== rtl/factor_base_trial_division.sv =====
// Factor-base trial division: a load transaction writes one prime into the table; a factor
// transaction divides the value by each prime in use in turn and gives one result per entry.
// Each trial division is done by a bit-serial divider. An entry that is divided has its prime
// read from the table, is divided (exponent + 1) times and passes its result to the output
// register. An entry that is skipped (zero value, value already reduced to plus or minus one,
// or a prime below two) goes through the wait, read and emit states with no division. A
// result waits in the output register while the sink holds off, and the block stalls with it.
// One transaction is worked on at a time; loads are taken on every cycle while idle.
// Depends on fbtd_pkg, fbtd_if and fbtd_divider.
module factor_base_trial_division #(
    parameter int BASE_DEPTH  = fbtd_pkg::BASE_DEPTH_DEF,
    parameter int VALUE_WIDTH = fbtd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fbtd_pkg::CNT_W-1:0]  i_cfg_wdata,
    fbtd_in_if.sink                     in_ch,
    fbtd_out_if.source                  out_ch
);
    import fbtd_pkg::*;
    localparam int AW = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
    localparam int LIM = (BASE_DEPTH < 64) ? BASE_DEPTH : 64;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV, S_WAIT, S_EMIT} t_state;

    logic [PRIME_W-1:0] r_mem [BASE_DEPTH];
    logic [PRIME_W-1:0] r_prime;
    logic [CNT_W-1:0]   r_cfg;
    t_state             r_state;
    logic [CNT_W-1:0]   r_k, r_n;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [EXP_W-1:0]   r_exp;
    logic               r_neg, r_zero, r_stop, r_even;
    logic               r_ov;
    logic [IDX_W-1:0]   r_pos;
    logic [EXP_W-1:0]   r_oexp;
    logic               r_last, r_smooth, r_alleven, r_zin;
    logic signed [FIELD_W-1:0] r_cof;

    logic                   w_start, w_done, w_exact;
    logic [VALUE_WIDTH-1:0] w_quot, w_raw, w_mag_in, w_cof;
    logic [CNT_W-1:0]       w_n;
    logic                   w_one, w_fin, w_emit;

    fbtd_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_dividend(r_mag),
        .i_divisor(r_prime), .o_done(w_done), .o_quotient(w_quot), .o_exact(w_exact)
    );

    always_comb begin
        w_raw    = in_ch.value[VALUE_WIDTH-1:0];
        w_mag_in = w_raw[VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
        w_n = (r_cfg == '0) ? CNT_W'(1) : r_cfg;
        if (w_n > CNT_W'(LIM)) w_n = CNT_W'(LIM);
        w_one = (r_mag == VALUE_WIDTH'(1));
        w_fin = (r_k + 1'b1 == r_n);
        w_cof = r_neg ? (~r_mag + 1'b1) : r_mag;
        w_start = (r_state == S_READ) && !r_zero && !r_stop && (r_prime >= PRIME_W'(2));
        w_emit = (r_state == S_EMIT) && (!r_ov || out_ch.ready);
    end

    assign in_ch.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready && in_ch.operation == OP_LOAD
            && 32'(in_ch.entry_index) < 32'(BASE_DEPTH))
            r_mem[AW'(in_ch.entry_index)] <= in_ch.prime_value;
        if (r_state == S_WAIT)
            r_prime <= r_mem[AW'(r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cfg <= CNT_W'(1); r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (w_emit) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.operation == OP_FACTOR) begin
                        r_n <= w_n; r_k <= '0; r_mag <= w_mag_in;
                        r_neg <= w_raw[VALUE_WIDTH-1]; r_zero <= (w_raw == '0);
                        r_stop <= 1'b0; r_even <= 1'b1; r_exp <= '0;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: r_state <= S_READ; // prime register loads for entry r_k
                S_READ: r_state <= w_start ? S_DIV : S_EMIT;
                S_DIV: begin
                    if (w_done) begin
                        if (w_exact) begin
                            r_mag <= w_quot; r_exp <= r_exp + 1'b1; r_state <= S_READ;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_pos <= r_k[IDX_W-1:0]; r_oexp <= r_exp; r_last <= w_fin;
                        r_cof <= w_fin ? FIELD_W'($signed(w_cof)) : '0;
                        r_smooth <= w_fin && !r_zero && w_one;
                        r_alleven <= w_fin && !r_zero && !r_neg && r_even && !r_exp[0];
                        r_zin <= w_fin && r_zero;
                        if (r_exp[0]) r_even <= 1'b0;
                        if (!r_zero && w_one) r_stop <= 1'b1;
                        r_exp <= '0;
                        r_k <= r_k + 1'b1;
                        r_state <= w_fin ? S_IDLE : S_WAIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid         = r_ov;
    assign out_ch.base_position = r_pos;
    assign out_ch.exponent      = r_oexp;
    assign out_ch.last          = r_last;
    assign out_ch.cofactor      = r_cof;
    assign out_ch.smooth        = r_smooth;
    assign out_ch.all_even      = r_alleven;
    assign out_ch.zero_input    = r_zin;
endmodule

// ===== rtl/fbtd_checker.sv =====
// Port-level checker for the trial division block, bound to its top level.
// Depends on fbtd_pkg and the channel interfaces.
module fbtd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_smooth,
    input logic out_zero_input,
    input logic out_all_even
);
    import fbtd_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_last |-> !out_smooth && !out_zero_input && !out_all_even)
        else $error("flags set on a result that is not last");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_zero_input |-> !out_smooth && !out_all_even)
        else $error("zero value reported smooth or even");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_last |-> !in_ready) else $error("input taken mid transaction");
endmodule

bind factor_base_trial_division fbtd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
    .out_smooth(out_ch.smooth), .out_zero_input(out_ch.zero_input),
    .out_all_even(out_ch.all_even)
);

// ===== dv/tb_factor_base_trial_division.sv =====
// Testbench for factor_base_trial_division: fills the prime table, runs directed factor and
// random transactions under several base counts, and checks every result against a predictor.
// Depends on fbtd_pkg, fbtd_if and the block RTL.
`timescale 1ns / 100ps

module tb_factor_base_trial_division;
    import fbtd_pkg::*;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int PRESSURE_HOLD  = 3000;

    typedef struct {
        bit [IDX_W-1:0]      position;
        bit [EXP_W-1:0]      exponent;
        bit                  last;
        bit [FIELD_W-1:0]    cofactor;
        bit                  smooth;
        bit                  all_even;
        bit                  zero_input;
    } factor_result_t;

    class factor_scoreboard;
        bit [PRIME_W-1:0] primes [BASE_DEPTH_DEF];
        bit [CNT_W-1:0]   base_count;
        factor_result_t   awaited[$];
        int               errors;

        function new();
            base_count = 1;
            errors = 0;
        endfunction

        task report(string what, bit [63:0] got, bit [63:0] want);
            $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        // Works out the results of one accepted transaction; loads only update the table.
        function void note_input(bit op, bit [IDX_W-1:0] idx, bit [PRIME_W-1:0] prime,
                                 bit [FIELD_W-1:0] value);
            bit [63:0] mag, p;
            bit [EXP_W-1:0] exps [BASE_DEPTH_DEF];
            bit neg, zero, stopped, even;
            int n, e;
            factor_result_t r;
            if (op == OP_LOAD) begin
                primes[idx] = prime;
                return;
            end
            n = (base_count == 0) ? 1 : (base_count > BASE_DEPTH_DEF) ? BASE_DEPTH_DEF
                                                                        : int'(base_count);
            neg = value[FIELD_W-1];
            mag = neg ? -value : value;
            zero = (mag == 0);
            stopped = 0;
            even = 1;
            for (int k = 0; k < n; k++) begin
                p = 64'(primes[k]);
                e = 0;
                if (!zero && !stopped && p >= 2) begin
                    while (mag % p == 0) begin
                        mag = mag / p;
                        e++;
                    end
                end
                if (!zero && mag == 1) stopped = 1;
                exps[k] = EXP_W'(e);
                if (e % 2 == 1) even = 0;
            end
            for (int k = 0; k < n; k++) begin
                r.position   = IDX_W'(k);
                r.exponent   = exps[k];
                r.last       = (k == n - 1);
                r.cofactor   = r.last ? (neg ? -mag : mag) : 64'd0;
                r.smooth     = r.last && !zero && mag == 1;
                r.all_even   = r.last && !zero && !neg && even;
                r.zero_input = r.last && zero;
                awaited.insert(awaited.size(), r);
            end
        endfunction

        task check_result(factor_result_t got);
            factor_result_t want;
            if (awaited.size() == 0) begin
                report("unexpected result, position", 64'(got.position), 64'd0);
                return;
            end
            want = awaited.pop_front();
            if (got.position != want.position)
                report("base_position", 64'(got.position), 64'(want.position));
            if (got.exponent != want.exponent)
                report("exponent", 64'(got.exponent), 64'(want.exponent));
            if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
            if (got.cofactor != want.cofactor) report("cofactor", got.cofactor, want.cofactor);
            if (got.smooth != want.smooth) report("smooth", 64'(got.smooth), 64'(want.smooth));
            if (got.all_even != want.all_even)
                report("all_even", 64'(got.all_even), 64'(want.all_even));
            if (got.zero_input != want.zero_input)
                report("zero_input", 64'(got.zero_input), 64'(want.zero_input));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    fbtd_in_if  in_ch();
    fbtd_out_if out_ch();

    factor_base_trial_division uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    factor_scoreboard sb = new();
    int unsigned small_primes [BASE_DEPTH_DEF];
    int results_seen = 0;
    int idle_cycles = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitors: both channels are sampled at the rising edge.
    always @(posedge i_clk) begin
        factor_result_t got;
        if (in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.operation, in_ch.entry_index, in_ch.prime_value, in_ch.value);
        if (out_ch.valid && out_ch.ready) begin
            got.position   = out_ch.base_position;
            got.exponent   = out_ch.exponent;
            got.last       = out_ch.last;
            got.cofactor   = out_ch.cofactor;
            got.smooth     = out_ch.smooth;
            got.all_even   = out_ch.all_even;
            got.zero_input = out_ch.zero_input;
            sb.check_result(got);
            results_seen++;
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: bursts of ready and gaps, with one long hold-off once results flow.
    initial begin
        int burst_left, gap_left;
        bit pressure_done;
        burst_left = 0;
        gap_left = 0;
        pressure_done = 0;
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && results_seen >= 40) begin
                out_ch.ready = 0;
                repeat (PRESSURE_HOLD) @(negedge i_clk);
                pressure_done = 1;
                out_ch.ready = 1;
            end else if (burst_left > 0) begin
                out_ch.ready = 1;
                burst_left--;
            end else if (gap_left > 0) begin
                out_ch.ready = 0;
                gap_left--;
            end else if ($urandom_range(0, 1)) begin
                out_ch.ready = 1;
                burst_left = $urandom_range(0, 40);
            end else begin
                gap_left = pick_gap();
                out_ch.ready = (gap_left == 0);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic send_item(bit op, bit [IDX_W-1:0] idx, bit [PRIME_W-1:0] prime,
                             bit [FIELD_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.operation   = op;
        in_ch.entry_index = idx;
        in_ch.prime_value = prime;
        in_ch.value       = value;
        in_ch.valid       = 1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The count may only change once the block is idle; a load gives no result, so wait after
    // the last result has arrived to let the block finish it.
    task automatic write_count(bit [CNT_W-1:0] count);
        in_ch.valid = 0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_wdata = count;
        i_cfg_we = 1;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.base_count = count;
    endtask

    function automatic bit [63:0] smooth_value();
        bit [63:0] mag, p;
        int n;
        n = (sb.base_count == 0) ? 1 : (sb.base_count > BASE_DEPTH_DEF) ? BASE_DEPTH_DEF
                                                                          : int'(sb.base_count);
        mag = 1;
        repeat ($urandom_range(1, 12)) begin
            p = 64'(sb.primes[$urandom_range(0, n - 1)]);
            if (p >= 2 && mag <= 64'h7FFF_FFFF_FFFF_FFFF / p) mag = mag * p;
        end
        if ($urandom_range(0, 3) == 0) mag = mag * 64'($urandom_range(1, 1000));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic send_random();
        int r;
        bit [63:0] v;
        bit [31:0] prime;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            r = $urandom_range(0, 9);
            prime = (r < 7) ? small_primes[$urandom_range(0, BASE_DEPTH_DEF - 1)]
                  : (r < 8) ? $urandom_range(0, 1) : $urandom;
            send_item(OP_LOAD, IDX_W'($urandom_range(0, BASE_DEPTH_DEF - 1)), prime,
                      {$urandom, $urandom});
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 55) v = smooth_value();
        else if (r < 80) v = {$urandom, $urandom};
        else if (r < 90) begin
            case ($urandom_range(0, 4))
                0: v = 0;
                1: v = 64'h8000_0000_0000_0000;
                2: v = 64'h7FFF_FFFF_FFFF_FFFF;
                3: v = 1;
                default: v = -64'sd1;
            endcase
        end else v = 64'(int'($urandom_range(0, 2000)) - 1000);
        send_item(OP_FACTOR, IDX_W'($urandom), $urandom, v);
    endtask

    initial begin
        int found, c;
        bit [CNT_W-1:0] phase_counts [9] = '{1, 3, 0, 127, 100, 8, 64, 16, 5};
        found = 0;
        c = 2;
        while (found < BASE_DEPTH_DEF) begin
            bit is_p;
            is_p = 1;
            for (int d = 2; d * d <= c; d++) if (c % d == 0) is_p = 0;
            if (is_p) small_primes[found++] = c;
            c++;
        end

        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        in_ch.valid = 0;
        in_ch.operation = OP_LOAD;
        in_ch.entry_index = 0;
        in_ch.prime_value = 0;
        in_ch.value = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Every entry is written before any factor transaction can read it. A prime of one
        // and one of zero divide nothing; the top entries hold the widest values.
        for (int k = 0; k < BASE_DEPTH_DEF; k++) begin
            bit [31:0] prime;
            prime = small_primes[k];
            if (k == 20) prime = 1;
            if (k == 21) prime = 0;
            if (k == 62) prime = 32'd4294967291;
            if (k == 63) prime = 32'hFFFF_FFFF;
            send_item(OP_LOAD, IDX_W'(k), prime, 0);
        end

        write_count(64);
        send_item(OP_FACTOR, 0, 0, 0);
        send_item(OP_FACTOR, 0, 0, 1);
        send_item(OP_FACTOR, 0, 0, -64'sd1);
        send_item(OP_FACTOR, 0, 0, 64'h8000_0000_0000_0000);
        send_item(OP_FACTOR, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_FACTOR, 0, 0, 64'h4000_0000_0000_0000);
        send_item(OP_FACTOR, 0, 0, 36);
        send_item(OP_FACTOR, 0, 0, -64'sd36);
        send_item(OP_FACTOR, 0, 0, 64'd4052555153018976267);
        send_item(OP_FACTOR, 0, 0, 64'd4294967291 * 3);
        send_item(OP_FACTOR, 0, 0, 64'hFFFF_FFFF * 2);
        send_item(OP_FACTOR, 0, 0, 64'd73 * 79);

        foreach (phase_counts[i]) begin
            write_count(phase_counts[i]);
            repeat (7) send_random();
        end

        in_ch.valid = 0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
